// ----- sv/bresenham_line_rasterizer_defines.svh -----
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BLR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define BLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/blr_pkg.sv -----
`timescale 1ns / 1ps

package blr_pkg;

   localparam int TILE_SIZE = 64;
   localparam int COORD_W   = 6;
   // signed coordinate difference
   localparam int DIFF_W    = COORD_W + 1;
   // decision variable stays within +-3*TILE_SIZE
   localparam int P_W       = COORD_W + 3;

   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(TILE_SIZE - 1);

   typedef struct packed {
      logic load;
      logic setup;
      logic step;
   } blr_cmd_type;

   typedef struct packed {
      logic last;
   } blr_sts_type;

   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] c;
      c = (v > COORD_MAX) ? COORD_MAX : v;
      return c;
   endfunction

endpackage

// ----- sv/blr_if.sv -----
`timescale 1ns / 1ps

interface blr_req_if;
   logic                        valid;
   logic                        ready;
   logic [blr_pkg::COORD_W-1:0] start_x;
   logic [blr_pkg::COORD_W-1:0] start_y;
   logic [blr_pkg::COORD_W-1:0] end_x;
   logic [blr_pkg::COORD_W-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface blr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [blr_pkg::COORD_W-1:0] pixel_x;
   logic [blr_pkg::COORD_W-1:0] pixel_y;
   logic                        last_pixel;

   modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ----- sv/bresenham_line_rasterizer.sv -----
`timescale 1ns / 1ps

// bresenham line rasterizer for one 64 by 64 tile
// req_if: one request is a segment (start_x, start_y, end_x, end_y); taken on
//    a rising edge with valid and ready high, ready only while the block is idle
// rsp_if: one item per pixel from start to end, both endpoints included;
//    last_pixel marks the final pixel; coordinates above the tile are saturated
// a segment with major length M = max(|dx|, |dy|) gives M + 1 pixels
// after a request is taken the block passes through a setup state, then
//    gives one pixel per cycle while rsp_if.ready is high; the single stepping
//    datapath works on one segment at a time
// stalls: a pixel held on rsp_if stays until taken and stepping waits with it
// reset: synchronous, active high; the controller returns to idle and any
//    segment in progress is dropped
module bresenham_line_rasterizer (
   input logic      clock,
   input logic      reset,
   blr_req_if.sink  req_if,
   blr_rsp_if.source rsp_if
);

   blr_pkg::blr_cmd_type cmd;
   blr_pkg::blr_sts_type sts;

   blr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   blr_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .start_x    (req_if.start_x),
      .start_y    (req_if.start_y),
      .end_x      (req_if.end_x),
      .end_y      (req_if.end_y),
      .pixel_x    (rsp_if.pixel_x),
      .pixel_y    (rsp_if.pixel_y),
      .last_pixel (rsp_if.last_pixel),
      .sts        (sts)
   );

endmodule

// ----- sv/blr_ctrl.sv -----
`timescale 1ns / 1ps

module blr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output blr_pkg::blr_cmd_type cmd,
   input  blr_pkg::blr_sts_type sts
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (rsp_ready && sts.last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RUN);

   assign cmd.load  = req_ready && req_valid;
   assign cmd.setup = (state_ff == ST_SETUP);
   assign cmd.step  = rsp_valid && rsp_ready;

endmodule

// ----- sv/blr_datapath.sv -----
`timescale 1ns / 1ps

module blr_datapath (
   input  logic                        clock,
   input  blr_pkg::blr_cmd_type        cmd,
   input  logic [blr_pkg::COORD_W-1:0] start_x,
   input  logic [blr_pkg::COORD_W-1:0] start_y,
   input  logic [blr_pkg::COORD_W-1:0] end_x,
   input  logic [blr_pkg::COORD_W-1:0] end_y,
   output logic [blr_pkg::COORD_W-1:0] pixel_x,
   output logic [blr_pkg::COORD_W-1:0] pixel_y,
   output logic                        last_pixel,
   output blr_pkg::blr_sts_type        sts
);

   logic [blr_pkg::COORD_W-1:0] x_ff, y_ff, ex_ff, ey_ff;
   logic [blr_pkg::COORD_W-1:0] x_in, y_in;
   logic [blr_pkg::COORD_W-1:0] remain_ff;
   logic signed [blr_pkg::P_W-1:0] p_ff, minor2_ff, diff2_ff;
   logic signed [blr_pkg::P_W-1:0] p_in;
   logic sx_neg_ff, sy_neg_ff, shallow_ff;

   // setup arithmetic on the latched endpoints
   logic signed [blr_pkg::DIFF_W-1:0] dx, dy, adx_full, ady_full;
   logic [blr_pkg::COORD_W-1:0] adx, ady, major, minor;
   logic shallow;
   logic signed [blr_pkg::P_W-1:0] minor2, major2;
   logic step_x, step_y;

   always_comb begin
      dx = $signed({1'b0, ex_ff}) - $signed({1'b0, x_ff});
      dy = $signed({1'b0, ey_ff}) - $signed({1'b0, y_ff});
      adx_full = dx[blr_pkg::DIFF_W-1] ? -dx : dx;
      ady_full = dy[blr_pkg::DIFF_W-1] ? -dy : dy;
      adx = adx_full[blr_pkg::COORD_W-1:0];
      ady = ady_full[blr_pkg::COORD_W-1:0];
      shallow = adx > ady;
      major = shallow ? adx : ady;
      minor = shallow ? ady : adx;
      minor2 = $signed({2'b00, minor, 1'b0});
      major2 = $signed({2'b00, major, 1'b0});
   end

   // minor axis advances when the decision variable is not negative
   always_comb begin
      step_x = shallow_ff || !p_ff[blr_pkg::P_W-1];
      step_y = !shallow_ff || !p_ff[blr_pkg::P_W-1];
      x_in = x_ff;
      y_in = y_ff;
      if (step_x) x_in = sx_neg_ff ? x_ff - blr_pkg::COORD_W'(1) : x_ff + blr_pkg::COORD_W'(1);
      if (step_y) y_in = sy_neg_ff ? y_ff - blr_pkg::COORD_W'(1) : y_ff + blr_pkg::COORD_W'(1);
      p_in = p_ff[blr_pkg::P_W-1] ? p_ff + minor2_ff : p_ff + diff2_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff  <= blr_pkg::clamp_coord(start_x);
         y_ff  <= blr_pkg::clamp_coord(start_y);
         ex_ff <= blr_pkg::clamp_coord(end_x);
         ey_ff <= blr_pkg::clamp_coord(end_y);
      end else if (cmd.step) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (cmd.setup) begin
         sx_neg_ff  <= dx[blr_pkg::DIFF_W-1];
         sy_neg_ff  <= dy[blr_pkg::DIFF_W-1];
         shallow_ff <= shallow;
         minor2_ff  <= minor2;
         diff2_ff   <= minor2 - major2;
         p_ff       <= minor2 - $signed({3'b000, major});
         remain_ff  <= major;
      end else if (cmd.step) begin
         p_ff      <= p_in;
         remain_ff <= remain_ff - blr_pkg::COORD_W'(1);
      end
   end

   assign pixel_x    = x_ff;
   assign pixel_y    = y_ff;
   assign last_pixel = (remain_ff == '0);
   assign sts.last   = last_pixel;

endmodule

// ----- sv/blr_checker.sv -----
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_defines.svh"

module blr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   `BLR_ASSERT_SAME(a_no_req_while_drawing, rsp_valid, !req_ready, "request accepted mid-line")
   `BLR_ASSERT_NEXT(a_setup_gap, req_valid && req_ready, !rsp_valid, "pixel shown in setup cycle")
   `BLR_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid, "stalled pixel dropped")
   `BLR_ASSERT_NEXT(a_end_after_last, rsp_valid && rsp_ready && rsp_last, !rsp_valid && req_ready,
      "pixels after the last one")

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_last  (rsp_if.last_pixel)
);

// ----- tb/bresenham_line_rasterizer_tb.sv -----
`timescale 1ns / 1ps

module bresenham_line_rasterizer_tb;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int RANDOM_SEGMENTS = 320;
   localparam int TAIL_CYCLES     = 70;
   localparam int MAX_REPORTS     = 40;

   typedef struct packed {
      logic [blr_pkg::COORD_W-1:0] start_x;
      logic [blr_pkg::COORD_W-1:0] start_y;
      logic [blr_pkg::COORD_W-1:0] end_x;
      logic [blr_pkg::COORD_W-1:0] end_y;
   } segment_type;

   typedef struct packed {
      logic [blr_pkg::COORD_W-1:0] x;
      logic [blr_pkg::COORD_W-1:0] y;
      logic                        last;
   } pixel_type;

   // typed rows carry their single pixel by hand, the rest go through the predictor
   typedef struct packed {
      segment_type seg;
      logic        typed;
      pixel_type   pix;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blr_req_if req_if ();
   blr_rsp_if rsp_if ();

   bresenham_line_rasterizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #10 clock = ~clock;

   directed_row_type directed_rows [] = '{
      // single-pixel segments at the corners and inside
      '{'{6'd0,  6'd0,  6'd0,  6'd0 }, 1'b1, '{6'd0,  6'd0,  1'b1}},
      '{'{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{6'd63, 6'd63, 1'b1}},
      '{'{6'd0,  6'd63, 6'd0,  6'd63}, 1'b1, '{6'd0,  6'd63, 1'b1}},
      '{'{6'd63, 6'd0,  6'd63, 6'd0 }, 1'b1, '{6'd63, 6'd0,  1'b1}},
      '{'{6'd21, 6'd42, 6'd21, 6'd42}, 1'b1, '{6'd21, 6'd42, 1'b1}},
      // full-tile rows, columns and diagonals both ways
      '{'{6'd0,  6'd0,  6'd63, 6'd0 }, 1'b0, '0},
      '{'{6'd63, 6'd63, 6'd0,  6'd63}, 1'b0, '0},
      '{'{6'd0,  6'd0,  6'd0,  6'd63}, 1'b0, '0},
      '{'{6'd63, 6'd63, 6'd63, 6'd0 }, 1'b0, '0},
      '{'{6'd0,  6'd0,  6'd63, 6'd63}, 1'b0, '0},
      '{'{6'd63, 6'd63, 6'd0,  6'd0 }, 1'b0, '0},
      '{'{6'd0,  6'd63, 6'd63, 6'd0 }, 1'b0, '0},
      '{'{6'd63, 6'd0,  6'd0,  6'd63}, 1'b0, '0},
      // one segment per octant from the centre, then one short segment
      '{'{6'd32, 6'd32, 6'd50, 6'd40}, 1'b0, '0},
      '{'{6'd32, 6'd32, 6'd40, 6'd50}, 1'b0, '0},
      '{'{6'd32, 6'd32, 6'd24, 6'd50}, 1'b0, '0},
      '{'{6'd32, 6'd32, 6'd14, 6'd40}, 1'b0, '0},
      '{'{6'd32, 6'd32, 6'd14, 6'd24}, 1'b0, '0},
      '{'{6'd32, 6'd32, 6'd24, 6'd14}, 1'b0, '0},
      '{'{6'd32, 6'd32, 6'd40, 6'd14}, 1'b0, '0},
      '{'{6'd32, 6'd32, 6'd50, 6'd24}, 1'b0, '0},
      '{'{6'd10, 6'd10, 6'd11, 6'd10}, 1'b0, '0}
   };

   pixel_type expected_pixels [$];
   int        mismatches  = 0;
   int        cycle_count = 0;
   int        burst_left  = 0;
   int        gap_left    = 0;

   // walk the decision variable and queue every pixel of the segment
   // coordinates are 6 bits wide, so the tile saturation never changes them
   function automatic void trace_segment(input segment_type s);
      logic signed [blr_pkg::P_W-1:0] dx, dy, major, minor, err;
      logic                           x_neg, y_neg, shallow;
      logic [blr_pkg::COORD_W-1:0]    cx, cy;
      pixel_type                      p;
      int                             i;
      dx = blr_pkg::P_W'(s.end_x) - blr_pkg::P_W'(s.start_x);
      dy = blr_pkg::P_W'(s.end_y) - blr_pkg::P_W'(s.start_y);
      x_neg = dx < 0;
      y_neg = dy < 0;
      if (x_neg) dx = -dx;
      if (y_neg) dy = -dy;
      shallow = dx > dy;
      major = shallow ? dx : dy;
      minor = shallow ? dy : dx;
      err = minor + minor - major;
      cx = s.start_x;
      cy = s.start_y;
      for (i = 0; i <= major; i++) begin
         p.x = cx;
         p.y = cy;
         p.last = (i == major);
         expected_pixels.push_back(p);
         if (shallow) cx = x_neg ? cx - 1'b1 : cx + 1'b1;
         else cy = y_neg ? cy - 1'b1 : cy + 1'b1;
         if (err < 0) begin
            err = err + minor + minor;
         end else begin
            err = err + minor + minor - major - major;
            if (shallow) cy = y_neg ? cy - 1'b1 : cy + 1'b1;
            else cx = x_neg ? cx - 1'b1 : cx + 1'b1;
         end
      end
   endfunction

   function automatic logic [blr_pkg::COORD_W-1:0] nearby_coord(
      input logic [blr_pkg::COORD_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > blr_pkg::TILE_SIZE - 1) v = blr_pkg::TILE_SIZE - 1;
      return blr_pkg::COORD_W'(v);
   endfunction

   task automatic send_segment(input segment_type s, input logic typed, input pixel_type pix);
      @(negedge clock);
      while (gap_left > 0) begin
         req_if.valid <= 1'b0;
         gap_left--;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.start_x <= s.start_x;
      req_if.start_y <= s.start_y;
      req_if.end_x   <= s.end_x;
      req_if.end_y   <= s.end_y;
      do @(posedge clock); while (!req_if.ready);
      if (typed) expected_pixels.push_back(pix);
      else trace_segment(s);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 8);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
   endtask

   task automatic drain_pixels();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // receiver: ready follows one of four stall patterns, chosen at random and changed periodically
   initial begin
      int mode, phase;
      rsp_if.ready = 1'b0;
      phase = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (phase % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_if.ready <= (phase % 4 != 3);
         endcase
         phase++;
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                        rsp_if.pixel_x, rsp_if.pixel_y, rsp_if.last_pixel);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_if.pixel_x !== want.x || rsp_if.pixel_y !== want.y ||
                rsp_if.last_pixel !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                           $time, want.x, want.y, want.last,
                           rsp_if.pixel_x, rsp_if.pixel_y, rsp_if.last_pixel);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      segment_type s;
      int          n, kind, room_x, room_y, d;
      logic        x_up, y_up;
      req_if.valid   = 1'b0;
      req_if.start_x = '0;
      req_if.start_y = '0;
      req_if.end_x   = '0;
      req_if.end_y   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_segment(directed_rows[r].seg, directed_rows[r].typed, directed_rows[r].pix);
      drain_pixels();

      for (n = 0; n < RANDOM_SEGMENTS; n++) begin
         // hold off now and then until the block has emptied
         if (n % 100 == 99) drain_pixels();
         kind = $urandom_range(0, 9);
         s.start_x = blr_pkg::COORD_W'($urandom);
         s.start_y = blr_pkg::COORD_W'($urandom);
         s.end_x   = blr_pkg::COORD_W'($urandom);
         s.end_y   = blr_pkg::COORD_W'($urandom);
         if (kind >= 4 && kind <= 7) begin
            s.end_x = nearby_coord(s.start_x);
            s.end_y = nearby_coord(s.start_y);
         end else if (kind == 8) begin
            s.end_x = s.start_x;
            s.end_y = s.start_y;
         end else if (kind == 9) begin
            // axis-aligned or diagonal runs
            case ($urandom_range(0, 2))
               0: s.end_y = s.start_y;
               1: s.end_x = s.start_x;
               default: begin
                  x_up = ($urandom_range(0, 1) == 1);
                  y_up = ($urandom_range(0, 1) == 1);
                  room_x = x_up ? blr_pkg::TILE_SIZE - 1 - int'(s.start_x) : int'(s.start_x);
                  room_y = y_up ? blr_pkg::TILE_SIZE - 1 - int'(s.start_y) : int'(s.start_y);
                  d = $urandom_range(0, (room_x < room_y) ? room_x : room_y);
                  s.end_x = x_up ? s.start_x + blr_pkg::COORD_W'(d)
                                 : s.start_x - blr_pkg::COORD_W'(d);
                  s.end_y = y_up ? s.start_y + blr_pkg::COORD_W'(d)
                                 : s.start_y - blr_pkg::COORD_W'(d);
               end
            endcase
         end
         send_segment(s, 1'b0, '0);
      end

      drain_pixels();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
